/* sv/sca_pkg.sv */
// ---------------------------------------------------------------------------
// sca_pkg
// Shared types and constants for the sparse coordinate-list matrix adder.
// ---------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  // store geometry and field widths
  localparam int Depth   = 32;
  localparam int IdxW    = $clog2(Depth);
  localparam int CntW    = $clog2(Depth + 1);
  localparam int CoordW  = 10;
  localparam int ValueW  = 32;

  // input item modes
  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_RUN    = 2'd2
  } mode_t;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_CMP  = 2'd2,
    ST_LAST = 2'd3
  } state_t;

  // one stored nonzero entry
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [ValueW-1:0] value;
  } entry_t;

  // one result word
  typedef struct packed {
    kind_t             kind;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [ValueW-1:0] value;
    logic              last;
    logic              ovf;
    logic              full;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // append input entry to store chosen by mode
    logic run_start;  // rewind both read pointers
    logic step;       // one merge decision on the registered read data
    logic finish;     // merge done: clear counts, make empty word if needed
    logic emit_last;  // move held word to output with last set
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic more;       // entries left in either store
    logic blocked;    // merge step needs the output register and it is busy
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

/* sv/sca_in_if.sv */
// ---------------------------------------------------------------------------
// sca_in_if
// Input channel: load and run words with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface sca_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [sca_pkg::CoordW-1:0] row;
  logic [sca_pkg::CoordW-1:0] col;
  logic [sca_pkg::ValueW-1:0] value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input mode, input row, input col, input value,
                  output ready);
endinterface

`default_nettype wire

/* sv/sca_out_if.sv */
// ---------------------------------------------------------------------------
// sca_out_if
// Result channel: load status and merged entries with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface sca_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [sca_pkg::CoordW-1:0] out_row;
  logic [sca_pkg::CoordW-1:0] out_col;
  logic [sca_pkg::ValueW-1:0] out_value;
  logic                       last;
  logic                       sum_overflow;
  logic                       store_full;

  modport source (output valid, output kind, output out_row, output out_col,
                  output out_value, output last, output sum_overflow,
                  output store_full, input ready);
  modport sink   (input valid, input kind, input out_row, input out_col,
                  input out_value, input last, input sum_overflow,
                  input store_full, output ready);
endinterface

`default_nettype wire

/* sv/sca_dp.sv */
// ---------------------------------------------------------------------------
// sca_dp
// Datapath: the two entry stores, counts, merge pointers and compare/add,
// a one-word hold register that lets the last flag be decided late, and
// the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sca_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sca_pkg::cmd_t              cmd,
  output      sca_pkg::sts_t              sts,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [sca_pkg::CoordW-1:0] in_row,
  input  wire logic [sca_pkg::CoordW-1:0] in_col,
  input  wire logic [sca_pkg::ValueW-1:0] in_value,
  sca_out_if.source                       out_ch
);

  // stores and their registered read data
  sca_pkg::entry_t a_mem [sca_pkg::Depth];
  sca_pkg::entry_t b_mem [sca_pkg::Depth];
  sca_pkg::entry_t a_rd_r;
  sca_pkg::entry_t b_rd_r;

  logic [sca_pkg::CntW-1:0] a_cnt_r;
  logic [sca_pkg::CntW-1:0] b_cnt_r;
  logic [sca_pkg::CntW-1:0] ia_r;
  logic [sca_pkg::CntW-1:0] ib_r;

  logic           pend_valid_r;
  sca_pkg::res_t  pend_r;
  logic           out_valid_r;
  sca_pkg::res_t  out_r;

  logic                       to_b;
  logic [sca_pkg::CntW-1:0]   sel_cnt;
  logic                       sel_full;
  sca_pkg::entry_t            wr_entry;
  logic                       a_ok;
  logic                       b_ok;
  logic [2*sca_pkg::CoordW-1:0] key_a;
  logic [2*sca_pkg::CoordW-1:0] key_b;
  logic                       match;
  logic                       take_a;
  logic [sca_pkg::ValueW:0]   sum;
  logic                       cand_emit;
  sca_pkg::res_t              cand;
  logic                       adv_a;
  logic                       adv_b;
  logic                       push;
  sca_pkg::res_t              push_data;
  sca_pkg::res_t              load_word;
  sca_pkg::res_t              empty_word;

  // load side
  assign to_b     = (in_mode == sca_pkg::MODE_LOAD_B);
  assign sel_cnt  = to_b ? b_cnt_r : a_cnt_r;
  assign sel_full = (sel_cnt == sca_pkg::CntW'(sca_pkg::Depth));
  assign wr_entry = '{row: in_row, col: in_col, value: in_value};

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !sel_full && !to_b) begin
      a_mem[sel_cnt[sca_pkg::IdxW-1:0]] <= wr_entry;
    end
    if (cmd.load && !sel_full && to_b) begin
      b_mem[sel_cnt[sca_pkg::IdxW-1:0]] <= wr_entry;
    end
    a_rd_r <= a_mem[ia_r[sca_pkg::IdxW-1:0]];
    b_rd_r <= b_mem[ib_r[sca_pkg::IdxW-1:0]];
  end

  // merge decision on the registered read data
  always_comb begin
    a_ok   = (ia_r < a_cnt_r);
    b_ok   = (ib_r < b_cnt_r);
    key_a  = {a_rd_r.row, a_rd_r.col};
    key_b  = {b_rd_r.row, b_rd_r.col};
    match  = a_ok && b_ok && (key_a == key_b);
    take_a = a_ok && (!b_ok || (key_a < key_b));
    sum    = {a_rd_r.value[sca_pkg::ValueW-1], a_rd_r.value}
           + {b_rd_r.value[sca_pkg::ValueW-1], b_rd_r.value};
    cand      = '0;
    cand.kind = sca_pkg::KIND_ENTRY;
    if (match) begin
      cand_emit  = (sum != '0);
      cand.row   = a_rd_r.row;
      cand.col   = a_rd_r.col;
      cand.value = sum[sca_pkg::ValueW-1:0];
      cand.ovf   = sum[sca_pkg::ValueW] ^ sum[sca_pkg::ValueW-1];
      adv_a      = 1'b1;
      adv_b      = 1'b1;
    end else if (take_a) begin
      cand_emit  = 1'b1;
      cand.row   = a_rd_r.row;
      cand.col   = a_rd_r.col;
      cand.value = a_rd_r.value;
      adv_a      = 1'b1;
      adv_b      = 1'b0;
    end else begin
      cand_emit  = 1'b1;
      cand.row   = b_rd_r.row;
      cand.col   = b_rd_r.col;
      cand.value = b_rd_r.value;
      adv_a      = 1'b0;
      adv_b      = 1'b1;
    end
  end

  // fixed status words
  always_comb begin
    load_word      = '0;
    load_word.kind = sca_pkg::KIND_LOAD;
    load_word.full = sel_full;
    empty_word      = '0;
    empty_word.kind = sca_pkg::KIND_EMPTY;
  end

  // output push: an earlier held word, or the final one with last set
  always_comb begin
    push_data = pend_r;
    push_data.last = cmd.emit_last;
    push = (cmd.step && cand_emit && pend_valid_r) || cmd.emit_last;
  end

  // status to controller
  always_comb begin
    sts.more     = (ia_r < a_cnt_r) || (ib_r < b_cnt_r);
    sts.out_free = !out_valid_r || out_ch.ready;
    sts.blocked  = cand_emit && pend_valid_r && !sts.out_free;
  end

  // counts and read pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      ia_r    <= '0;
      ib_r    <= '0;
    end else begin
      if (cmd.load && !sel_full && !to_b) begin
        a_cnt_r <= a_cnt_r + 1'b1;
      end
      if (cmd.load && !sel_full && to_b) begin
        b_cnt_r <= b_cnt_r + 1'b1;
      end
      if (cmd.finish) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end
      if (cmd.run_start) begin
        ia_r <= '0;
        ib_r <= '0;
      end else if (cmd.step) begin
        if (adv_a) begin
          ia_r <= ia_r + 1'b1;
        end
        if (adv_b) begin
          ib_r <= ib_r + 1'b1;
        end
      end
    end
  end

  // hold register: one word kept back until its last flag is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load) begin
      pend_valid_r <= 1'b1;
      pend_r       <= load_word;
    end else if (cmd.step && cand_emit) begin
      pend_valid_r <= 1'b1;
      pend_r       <= cand;
    end else if (cmd.finish && !pend_valid_r) begin
      pend_valid_r <= 1'b1;
      pend_r       <= empty_word;
    end else if (cmd.emit_last) begin
      pend_valid_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
      out_r       <= push_data;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.out_row      = out_r.row;
  assign out_ch.out_col      = out_r.col;
  assign out_ch.out_value    = out_r.value;
  assign out_ch.last         = out_r.last;
  assign out_ch.sum_overflow = out_r.ovf;
  assign out_ch.store_full   = out_r.full;

endmodule

`default_nettype wire

/* sv/sca_ctrl.sv */
// ---------------------------------------------------------------------------
// sca_ctrl
// Controller: takes input words, sequences the read/compare merge loop and
// the final word of each item.
// ---------------------------------------------------------------------------
`default_nettype none

module sca_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_mode,
  output      logic          in_ready,
  input  wire sca_pkg::sts_t sts,
  output      sca_pkg::cmd_t cmd
);

  sca_pkg::state_t state_r;
  sca_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sca_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode) inside
            sca_pkg::MODE_LOAD_A, sca_pkg::MODE_LOAD_B: begin
              cmd.load  = 1'b1;
              state_nxt = sca_pkg::ST_LAST;
            end
            sca_pkg::MODE_RUN: begin
              cmd.run_start = 1'b1;
              state_nxt     = sca_pkg::ST_READ;
            end
            default: begin
              state_nxt = sca_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sca_pkg::ST_READ: begin
        if (sts.more) begin
          state_nxt = sca_pkg::ST_CMP;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = sca_pkg::ST_LAST;
        end
      end
      sca_pkg::ST_CMP: begin
        if (!sts.blocked) begin
          cmd.step  = 1'b1;
          state_nxt = sca_pkg::ST_READ;
        end
      end
      sca_pkg::ST_LAST: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = sca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/sparse_coo_matrix_add_top.sv */
// ---------------------------------------------------------------------------
// sparse_coo_matrix_add_top
// Sparse matrix adder over two coordinate-list stores, merged on demand.
// ---------------------------------------------------------------------------
// Load words (mode 0 or 1) append one (row, col, value) entry to store A or
// B, 32 entries each, and return one status word with last set and
// store_full set if the entry was refused. A run word (mode 2) merges both
// stores by (row, col): each merge step is a read state and then a
// compare/add state against the registered store read ports, and the run
// ends with a final read and the last word. Equal positions are summed, zero
// sums dropped, wrapped sums flagged; the last word of a run carries last,
// an empty result gives one word of kind 2, and both stores are emptied.
// Mode 3 is taken and ignored. Output backpressure stalls the merge; the
// input is taken only between items.
// ---------------------------------------------------------------------------
`default_nettype none

module sparse_coo_matrix_add_top (
  input  wire logic clk,
  input  wire logic rst_n,
  sca_in_if.sink    in_ch,
  sca_out_if.source out_ch
);

  sca_pkg::cmd_t cmd;
  sca_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  // controller
  sca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sca_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_mode  (in_ch.mode),
    .in_row   (in_ch.row),
    .in_col   (in_ch.col),
    .in_value (in_ch.value),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* verif/sca_tb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sca_tb_pkg
// Scoreboard for the sparse matrix adder. It keeps its own copy of stores A
// and B, works out the status and merged-entry words that each accepted
// input word should produce, and checks every output word field by field
// against the oldest word still due.
// ---------------------------------------------------------------------------

package sca_tb_pkg;
  import sca_pkg::*;

  // mode value that the block accepts and then ignores
  localparam logic [1:0] MODE_SKIP = 2'd3;

  // one input word
  typedef struct packed {
    logic [1:0]        mode;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [ValueW-1:0] value;
  } in_word_t;

  class matrix_sum_board;
    entry_t      a_store[Depth];
    entry_t      b_store[Depth];
    int unsigned a_cnt;
    int unsigned b_cnt;
    res_t        words_due[$];
    int unsigned errors;

    function new();
      a_cnt  = 0;
      b_cnt  = 0;
      errors = 0;
    endfunction

    function logic [2*CoordW-1:0] key_of(entry_t e);
      return {e.row, e.col};
    endfunction

    function res_t make_word(kind_t kind, entry_t e, logic ovf, logic full);
      res_t r;
      r.kind  = kind;
      r.row   = e.row;
      r.col   = e.col;
      r.value = e.value;
      r.last  = 1'b0;
      r.ovf   = ovf;
      r.full  = full;
      return r;
    endfunction

    // row-major merge of both stores, then both stores are emptied
    function void add_stores();
      int unsigned ia;
      int unsigned ib;
      int unsigned first_idx;
      longint      total;
      longint      wrapped;
      entry_t      e;
      res_t        r;
      ia = 0;
      ib = 0;
      first_idx = words_due.size();
      while (ia < a_cnt || ib < b_cnt) begin
        if (ia < a_cnt && ib < b_cnt && key_of(a_store[ia]) == key_of(b_store[ib])) begin
          // matched position: true sum, dropped only when exactly zero
          total = longint'($signed(a_store[ia].value)) + longint'($signed(b_store[ib].value));
          if (total != 0) begin
            e       = a_store[ia];
            e.value = total[ValueW-1:0];
            wrapped = longint'($signed(e.value));
            words_due.push_back(make_word(KIND_ENTRY, e, wrapped != total, 1'b0));
          end
          ia++;
          ib++;
        end else if (ia < a_cnt &&
                     (ib >= b_cnt || key_of(a_store[ia]) < key_of(b_store[ib]))) begin
          words_due.push_back(make_word(KIND_ENTRY, a_store[ia], 1'b0, 1'b0));
          ia++;
        end else begin
          words_due.push_back(make_word(KIND_ENTRY, b_store[ib], 1'b0, 1'b0));
          ib++;
        end
      end
      // nothing survived the merge: one empty-matrix word
      if (words_due.size() == first_idx) begin
        words_due.push_back(make_word(KIND_EMPTY, '0, 1'b0, 1'b0));
      end
      r = words_due.pop_back();
      r.last = 1'b1;
      words_due.push_back(r);
      a_cnt = 0;
      b_cnt = 0;
    endfunction

    // accepted input word
    function void note_word(in_word_t w);
      entry_t e;
      logic   full;
      res_t   r;
      e.row   = w.row;
      e.col   = w.col;
      e.value = w.value;
      case (w.mode)
        MODE_LOAD_A: begin
          full = (a_cnt >= Depth);
          if (!full) begin
            a_store[a_cnt] = e;
            a_cnt++;
          end
        end
        MODE_LOAD_B: begin
          full = (b_cnt >= Depth);
          if (!full) begin
            b_store[b_cnt] = e;
            b_cnt++;
          end
        end
        MODE_RUN: begin
          add_stores();
          return;
        end
        default: begin
          return;
        end
      endcase
      r = make_word(KIND_LOAD, '0, 1'b0, full);
      r.last = 1'b1;
      words_due.push_back(r);
    endfunction

    function void check_field(string name, logic [ValueW-1:0] want, logic [ValueW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // accepted output word
    function void check_word(res_t got);
      res_t want;
      if (words_due.size() == 0) begin
        $error("output word with nothing due: kind %0d row %0d col %0d value %0h",
               got.kind, got.row, got.col, got.value);
        errors++;
        return;
      end
      want = words_due.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("out_row", want.row, got.row);
      check_field("out_col", want.col, got.col);
      check_field("out_value", want.value, got.value);
      check_field("last", want.last, got.last);
      check_field("sum_overflow", want.ovf, got.ovf);
      check_field("store_full", want.full, got.full);
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse coordinate-list matrix adder. A short
// directed part hits the corner cases, then random matrix pairs are loaded
// and merged under random gaps and output stalls; every output word is
// checked against the word that the scoreboard works out for it.
// ---------------------------------------------------------------------------

module tb_top;
  import sca_pkg::*;
  import sca_tb_pkg::*;

  localparam int LoadItems   = 320;
  localparam int CalmAfter   = 280;
  localparam int DrainCycles = 200;
  localparam int StallLimit  = 4000;

  localparam int ShapeFew   = 0;
  localparam int ShapeFlood = 1;
  localparam int ShapeWide  = 2;

  localparam int KeyW = 2 * CoordW;

  logic        clk;
  logic        rst_n;
  logic        calm_tail = 1'b0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;

  matrix_sum_board sum_chk;

  sca_in_if  in_ch ();
  sca_out_if out_ch ();

  sparse_coo_matrix_add_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t rand_word(logic [1:0] mode);
    in_word_t w;
    w.mode  = mode;
    w.row   = CoordW'($urandom());
    w.col   = CoordW'($urandom());
    w.value = $urandom();
    return w;
  endfunction

  // one word through the input handshake, with an optional gap ahead of it
  task automatic send_word(in_word_t w);
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= w.mode;
    in_ch.row   <= w.row;
    in_ch.col   <= w.col;
    in_ch.value <= w.value;
    do @(posedge clk); while (!in_ch.ready);
    sum_chk.note_word(w);
    if (w.mode != MODE_SKIP) words_sent++;
    if (words_sent >= CalmAfter) calm_tail = 1'b1;
  endtask

  task automatic load_entry(logic [1:0] mode, int row, int col, logic [ValueW-1:0] value);
    in_word_t w;
    w.mode  = mode;
    w.row   = CoordW'(row);
    w.col   = CoordW'(col);
    w.value = value;
    send_word(w);
  endtask

  // hold the input until every word due has come out
  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sum_chk.words_due.size() != 0);
  endtask

  // load a random matrix pair into A and B, then merge
  task automatic play_matrices(int shape);
    logic [KeyW-1:0]   keys[$];
    in_word_t          a_list[$];
    in_word_t          b_list[$];
    in_word_t          w;
    in_word_t          tmp;
    logic [ValueW-1:0] va;
    logic [ValueW-1:0] vb;
    int                n;
    int                span;
    int                lo;
    int                sel;
    int                target;
    case (shape)
      ShapeFlood: n = $urandom_range(35, 40);
      ShapeWide:  n = $urandom_range(64, 70);
      default:    n = $urandom_range(0, 8);
    endcase
    // dense window most of the time, the whole key space sometimes
    if (shape == ShapeFlood || $urandom_range(0, 3) == 0) span = (1 << KeyW) - 1;
    else span = n * 3 + 2;
    lo = $urandom_range(0, (1 << KeyW) - 1 - span);
    for (int i = 0; i < n; i++) keys.push_back(KeyW'(lo + $urandom_range(0, span)));
    keys.sort();
    target = $urandom_range(0, 1);
    for (int i = 0; i < keys.size(); i++) begin
      if (i != 0 && keys[i] == keys[i-1]) continue;
      // 0 A only, 1 B only, 2 both
      case (shape)
        ShapeFlood: sel = ($urandom_range(0, 3) == 0) ? 2 : target;
        ShapeWide:  sel = $urandom_range(0, 1);
        default:    sel = $urandom_range(0, 2);
      endcase
      va = pick_value();
      case ($urandom_range(0, 3))
        0:       vb = -va;
        1:       vb = va;
        default: vb = pick_value();
      endcase
      w.row   = keys[i][KeyW-1:CoordW];
      w.col   = keys[i][CoordW-1:0];
      if (sel != 1) begin
        w.mode  = MODE_LOAD_A;
        w.value = va;
        a_list.push_back(w);
      end
      if (sel != 0) begin
        w.mode  = MODE_LOAD_B;
        w.value = vb;
        b_list.push_back(w);
      end
    end
    // now and then an out-of-order store
    if ($urandom_range(0, 7) == 0 && a_list.size() > 1) begin
      tmp = a_list[0];
      a_list[0] = a_list[a_list.size()-1];
      a_list[a_list.size()-1] = tmp;
    end
    // interleave the two load streams, with stray unused-mode words
    while (a_list.size() + b_list.size() != 0) begin
      if ($urandom_range(0, 11) == 0) send_word(rand_word(MODE_SKIP));
      if (b_list.size() == 0 || (a_list.size() != 0 && $urandom_range(0, 1) == 0))
        send_word(a_list.pop_front());
      else
        send_word(b_list.pop_front());
    end
    send_word(rand_word(MODE_RUN));
  endtask

  // stimulus
  initial begin
    int shape;
    sum_chk = new();
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_SKIP;
    in_ch.row   <= '0;
    in_ch.col   <= '0;
    in_ch.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // merge of two empty stores, then an unused mode
    send_word(rand_word(MODE_RUN));
    send_word(rand_word(MODE_SKIP));
    // zero sum dropped, positive overflow, zero value kept, wrap to zero flagged
    load_entry(MODE_LOAD_A, 0, 0, 1);
    load_entry(MODE_LOAD_A, 0, 5, 32'h7FFF_FFFF);
    load_entry(MODE_LOAD_A, 1023, 1023, 32'h8000_0000);
    load_entry(MODE_LOAD_B, 0, 0, -1);
    load_entry(MODE_LOAD_B, 0, 5, 1);
    load_entry(MODE_LOAD_B, 2, 3, 0);
    load_entry(MODE_LOAD_B, 1023, 1023, 32'h8000_0000);
    send_word(rand_word(MODE_RUN));
    // store A out of row-major order
    load_entry(MODE_LOAD_A, 5, 0, 7);
    load_entry(MODE_LOAD_A, 1, 1, 3);
    load_entry(MODE_LOAD_B, 3, 3, 4);
    load_entry(MODE_LOAD_B, 0, 1023, -5);
    send_word(rand_word(MODE_RUN));
    // every entry cancels: empty result
    load_entry(MODE_LOAD_A, 7, 7, 5);
    load_entry(MODE_LOAD_B, 7, 7, -5);
    send_word(rand_word(MODE_RUN));
    // B only
    load_entry(MODE_LOAD_B, 1023, 0, 32'h8000_0000);
    send_word(rand_word(MODE_RUN));
    drain_wait();

    // random matrix pairs, the first one overfilling a store
    shape = ShapeFlood;
    while (words_sent < LoadItems) begin
      play_matrices(shape);
      if ($urandom_range(0, 9) == 0) drain_wait();
      case ($urandom_range(0, 15))
        0:       shape = ShapeFlood;
        1:       shape = ShapeWide;
        default: shape = ShapeFew;
      endcase
    end

    drain_wait();
    repeat (DrainCycles) @(posedge clk);
    if (sum_chk.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // output ready: random stall bursts, calm stretches, none at the tail
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left != 0) calm_left--;
      else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(40, 160);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm_tail && calm_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind  = kind_t'(out_ch.kind);
      got.row   = out_ch.out_row;
      got.col   = out_ch.out_col;
      got.value = out_ch.out_value;
      got.last  = out_ch.last;
      got.ovf   = out_ch.sum_overflow;
      got.full  = out_ch.store_full;
      sum_chk.check_word(got);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
